// ----- hdl/sorted_priority_queue_top_defines.svh -----
// Assertion macros shared by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

// ----- hdl/spq_pkg.sv -----
// Shared constants, codes and types of the sorted priority queue.
package spq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned DataW    = 32;
  localparam int unsigned OutPosW  = 5;
  localparam int unsigned OutCntW  = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load;  // capture the incoming request word
    logic exec;  // carry out the captured request
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [DataW-1:0]   out_priority;
    logic [DataW-1:0]   out_value;
    logic [OutPosW-1:0] found_position;
    logic [OutCntW-1:0] entry_count;
  } resp_t;

endpackage

// ----- hdl/spq_ctrl.sv -----
// Handshake and sequencing controller of the sorted priority queue.
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output spq_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_DONE) && out_ready_i);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = in_valid_i ? S_EXEC : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_d == S_DONE);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/spq_datapath.sv -----
// Sorted entry table, request register and result register.
module spq_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spq_pkg::cmd_t               cmd_i,
  input  logic [1:0]                  req_type_i,
  input  logic [spq_pkg::DataW-1:0]   item_value_i,
  input  logic [spq_pkg::DataW-1:0]   item_priority_i,
  output spq_pkg::resp_t              resp_o
);

  logic [1:0]                req_q;
  logic [spq_pkg::DataW-1:0] val_q;
  logic [spq_pkg::DataW-1:0] pri_q;

  logic [spq_pkg::DataW-1:0] ent_val_q [spq_pkg::Capacity];
  logic [spq_pkg::DataW-1:0] ent_pri_q [spq_pkg::Capacity];
  logic [spq_pkg::DataW-1:0] ent_val_d [spq_pkg::Capacity];
  logic [spq_pkg::DataW-1:0] ent_pri_d [spq_pkg::Capacity];
  logic [spq_pkg::CntW-1:0]  count_q, count_d;
  spq_pkg::resp_t            resp_q, resp_d;

  logic [spq_pkg::Capacity-1:0] ge;
  logic [spq_pkg::Capacity-1:0] match;
  logic [spq_pkg::CntW-1:0]     pos;
  logic                         hit;

  // Held entries whose priority is at or above the new one form a prefix.
  always_comb begin
    for (int i = 0; i < spq_pkg::Capacity; i++) begin
      ge[i]    = (spq_pkg::CntW'(i) < count_q) &&
                 ($signed(ent_pri_q[i]) >= $signed(pri_q));
      match[i] = (spq_pkg::CntW'(i) < count_q) && (ent_val_q[i] == val_q);
    end
  end

  // First match from the head wins.
  always_comb begin
    pos = '0;
    hit = 1'b0;
    for (int i = spq_pkg::Capacity - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = spq_pkg::CntW'(i + 1);
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < spq_pkg::Capacity; i++) begin
      ent_val_d[i] = ent_val_q[i];
      ent_pri_d[i] = ent_pri_q[i];
    end
    count_d = count_q;
    resp_d  = '0;
    case (req_q)
      spq_pkg::REQ_INSERT: begin
        if (count_q == spq_pkg::CntW'(spq_pkg::Capacity)) begin
          resp_d.status = spq_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < spq_pkg::Capacity; i++) begin
            if (!ge[i]) begin
              if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
                ent_val_d[i] = val_q;
                ent_pri_d[i] = pri_q;
              end else begin
                ent_val_d[i] = ent_val_q[(i == 0) ? 0 : i - 1];
                ent_pri_d[i] = ent_pri_q[(i == 0) ? 0 : i - 1];
              end
            end
          end
          count_d = count_q + 1'b1;
        end
      end
      spq_pkg::REQ_REMOVE: begin
        if (count_q == '0) begin
          resp_d.status = spq_pkg::ST_EMPTY;
        end else begin
          resp_d.out_value    = ent_val_q[0];
          resp_d.out_priority = ent_pri_q[0];
          for (int i = 0; i < spq_pkg::Capacity - 1; i++) begin
            ent_val_d[i] = ent_val_q[i + 1];
            ent_pri_d[i] = ent_pri_q[i + 1];
          end
          count_d = count_q - 1'b1;
        end
      end
      spq_pkg::REQ_SEARCH: begin
        resp_d.status         = hit ? spq_pkg::ST_OK : spq_pkg::ST_NOTFOUND;
        resp_d.found_position = spq_pkg::OutPosW'(pos);
      end
      default: ;
    endcase
    resp_d.entry_count = spq_pkg::OutCntW'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      val_q <= item_value_i;
      pri_q <= item_priority_i;
    end
    if (cmd_i.exec) begin
      resp_q <= resp_d;
      for (int i = 0; i < spq_pkg::Capacity; i++) begin
        ent_val_q[i] <= ent_val_d[i];
        ent_pri_q[i] <= ent_pri_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign resp_o = resp_q;

endmodule

// ----- hdl/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: controller plus datapath.
//
// A request word enters on the slave stream. s_axis_tuser carries the
// request kind (insert, remove head, search by value), and s_axis_tdata
// carries the value in the low half and the priority in the high half.
// Every request gives exactly one result word on the master stream:
// m_axis_tuser carries the status, m_axis_tdata the removed value and
// priority, the search position and the entry count after the request.
// Entries are kept sorted by signed priority, highest at the head, and
// equal priorities leave in arrival order.
// A word is captured, then executed in the next cycle, where all
// sixteen table cells compare against the request at once and shift in
// a single step; the result word is offered from the execute edge on
// and can leave at the following edge. The controller takes no new
// request until the result word leaves, so requests never overlap in
// its capture and execute steps.
// If the receiver stalls, the result word holds and no new request is
// taken until it leaves; a new request may be taken in the cycle that it
// leaves. Reset empties the table and drops any pending result word.
module sorted_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // item_value[31:0], item_priority[63:32]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // out_value[31:0], out_priority[63:32],
                                      // found_position[68:64], entry_count[73:69],
                                      // zero fill[79:74]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::resp_t resp;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (s_axis_tuser),
    .item_value_i    (s_axis_tdata[31:0]),
    .item_priority_i (s_axis_tdata[63:32]),
    .resp_o          (resp)
  );

  // Pack the result word, lowest field first.
  assign m_axis_tuser = resp.status;
  assign m_axis_tdata = {6'd0, resp.entry_count, resp.found_position,
                         resp.out_priority, resp.out_value};

endmodule

// ----- hdl/spq_checker.sv -----
// Port-level checks of the sorted priority queue and their binding.
`include "sorted_priority_queue_top_defines.svh"

module spq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic       out_stall;
  logic       empty_word;
  logic       full_word;
  logic [4:0] word_count;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign empty_word = m_axis_tvalid && (m_axis_tuser == spq_pkg::ST_EMPTY);
  assign full_word  = m_axis_tvalid && (m_axis_tuser == spq_pkg::ST_FULL);
  assign word_count = m_axis_tdata[73:69];

  // A stalled result word stays offered.
  `SPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid)

  // No request is taken while a result word is stalled.
  `SPQ_ASSERT_SAME(a_no_take_stalled, clk_i, rst_ni, out_stall, !s_axis_tready)

  // A removal from an empty table reports nothing held and zero payload.
  `SPQ_ASSERT_SAME(a_empty_zero, clk_i, rst_ni, empty_word, m_axis_tdata[73:0] == 74'd0)

  // A full report comes only with a full table.
  `SPQ_ASSERT_SAME(a_full_count, clk_i, rst_ni, full_word, word_count == 5'(spq_pkg::Capacity))

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/sorted_priority_queue_top_tb.sv -----
// Self-checking testbench of the sorted priority queue top level.
module sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         ItemsPerPhase = 300;
  localparam int         HoldCycles    = 300;
  localparam int         QuietLimit    = 4000;

  // Predicts the queue contents and keeps the result words still owed by the block.
  class queue_scoreboard;
    logic [spq_pkg::DataW-1:0]        held_value[$];
    logic signed [spq_pkg::DataW-1:0] held_prio[$];
    spq_pkg::resp_t                   owed_words[$];
    int unsigned                      errors = 0;

    function void note_request(logic [1:0] req, logic [spq_pkg::DataW-1:0] val,
                               logic signed [spq_pkg::DataW-1:0] prio);
      spq_pkg::resp_t want;
      int             slot;
      want = '0;
      want.status = spq_pkg::ST_OK;
      case (req)
        spq_pkg::REQ_INSERT: begin
          if (held_value.size() >= spq_pkg::Capacity) begin
            want.status = spq_pkg::ST_FULL;
          end else begin
            // Equal priorities stay behind the ones already held.
            slot = 0;
            while (slot < held_prio.size() && held_prio[slot] >= prio) slot++;
            held_value.insert(slot, val);
            held_prio.insert(slot, prio);
          end
        end
        spq_pkg::REQ_REMOVE: begin
          if (held_value.size() == 0) begin
            want.status = spq_pkg::ST_EMPTY;
          end else begin
            want.out_value    = held_value.pop_front();
            want.out_priority = held_prio.pop_front();
          end
        end
        spq_pkg::REQ_SEARCH: begin
          want.status = spq_pkg::ST_NOTFOUND;
          for (int k = 0; k < held_value.size() && want.status == spq_pkg::ST_NOTFOUND;
               k++) begin
            if (held_value[k] == val) begin
              want.found_position = spq_pkg::OutPosW'(k + 1);
              want.status         = spq_pkg::ST_OK;
            end
          end
        end
        default: ;
      endcase
      want.entry_count = spq_pkg::OutCntW'(held_value.size());
      owed_words.push_back(want);
    endfunction

    function void compare_field(string name, logic [spq_pkg::DataW-1:0] want_v,
                                logic [spq_pkg::DataW-1:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_result(logic [79:0] data, logic [1:0] user);
      spq_pkg::resp_t want;
      if (owed_words.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, actual %h/%h",
                 $time, user, data);
        return;
      end
      want = owed_words.pop_front();
      compare_field("status", spq_pkg::DataW'(want.status), spq_pkg::DataW'(user));
      compare_field("out_value", want.out_value, data[31:0]);
      compare_field("out_priority", want.out_priority, data[63:32]);
      compare_field("found_position", spq_pkg::DataW'(want.found_position),
                    spq_pkg::DataW'(data[68:64]));
      compare_field("entry_count", spq_pkg::DataW'(want.entry_count),
                    spq_pkg::DataW'(data[73:69]));
      compare_field("zero fill", '0, spq_pkg::DataW'(data[79:74]));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // item_value[31:0], item_priority[63:32]
  logic [1:0]  s_axis_tuser  = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;         // out_value, out_priority, found_position,
                                     // entry_count, zero fill
  logic [1:0]  m_axis_tuser;         // status[1:0]

  queue_scoreboard board;
  int          send_idle_pct = 0;
  int          rx_stall_pct  = 0;
  bit          hold_request  = 1'b0;
  int unsigned quiet_cycles  = 0;

  sorted_priority_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Both handshakes are sampled at the edge, before any driver update of that
  // edge takes effect. A result is checked before the request of the same edge
  // is noted; the result always belongs to an older request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        board.note_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("sorted_priority_queue_top regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so that the
  // result register stays full and the block must refuse new words.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offers one word, with random idle cycles first, and returns at the edge
  // where it is taken. tvalid is assigned once per edge.
  task automatic send_word(logic [1:0] req, logic [spq_pkg::DataW-1:0] val,
                           logic [spq_pkg::DataW-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {prio, val};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Empty-table cases, field extremes, priority ties, a full table and
  // searches that hit the head, hit the tail and miss.
  task automatic run_directed();
    logic [spq_pkg::DataW-1:0] val;
    logic [spq_pkg::DataW-1:0] prio;
    send_word(spq_pkg::REQ_REMOVE, '0, '0);
    send_word(spq_pkg::REQ_SEARCH, '0, '0);
    send_word(REQ_UNUSED, '1, '1);
    for (int i = 0; i < spq_pkg::Capacity; i++) begin
      case (i)
        0:       begin val = 32'h8000_0000; prio = 32'h8000_0000; end
        1:       begin val = 32'h7fff_ffff; prio = 32'h7fff_ffff; end
        2:       begin val = 32'hffff_ffff; prio = 32'hffff_ffff; end
        3:       begin val = '0;            prio = '0;            end
        default: begin val = spq_pkg::DataW'(i * 3); prio = 32'd5; end
      endcase
      send_word(spq_pkg::REQ_INSERT, val, prio);
    end
    send_word(spq_pkg::REQ_INSERT, 32'h1234_5678, 32'h7fff_ffff);
    send_word(spq_pkg::REQ_SEARCH, 32'h7fff_ffff, '0);
    send_word(spq_pkg::REQ_SEARCH, 32'h8000_0000, '0);
    send_word(spq_pkg::REQ_SEARCH, 32'h5555_5555, '0);
    send_word(REQ_UNUSED, 32'ha5a5_5a5a, 32'h0f0f_f0f0);
    send_word(spq_pkg::REQ_REMOVE, '0, '0);
    send_word(spq_pkg::REQ_REMOVE, '0, '0);
  endtask

  // Values come mostly from a small pool so that searches hit and repeat;
  // priorities are often tied so that arrival order is exercised.
  task automatic send_random_item(int n);
    logic [1:0]                req;
    logic [spq_pkg::DataW-1:0] val;
    logic [spq_pkg::DataW-1:0] prio;
    int                        pick;
    pick = $urandom_range(99);
    // Alternate between filling and draining runs so the table reaches
    // both full and empty often.
    if (((n / 32) % 2) == 0) begin
      req = (pick < 60) ? spq_pkg::REQ_INSERT : (pick < 75) ? spq_pkg::REQ_REMOVE :
            (pick < 97) ? spq_pkg::REQ_SEARCH : REQ_UNUSED;
    end else begin
      req = (pick < 15) ? spq_pkg::REQ_INSERT : (pick < 70) ? spq_pkg::REQ_REMOVE :
            (pick < 97) ? spq_pkg::REQ_SEARCH : REQ_UNUSED;
    end
    val  = ($urandom_range(99) < 70) ? spq_pkg::DataW'($urandom_range(11)) : $urandom;
    prio = ($urandom_range(99) < 50) ?
           spq_pkg::DataW'(int'($urandom_range(4)) - 2) : $urandom;
    send_word(req, val, prio);
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin send_idle_pct = 48; rx_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin send_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // The sender keeps offering words through the long hold-off.
        if (phase == 0 && n == 100) hold_request = 1'b1;
        send_random_item(n);
      end
    end
    s_axis_tvalid <= 1'b0;
    rx_stall_pct = 0;
    @(posedge clk_i);
    while (board.owed_words.size() != 0) @(posedge clk_i);
    // A final wait after the last owed result catches stray result words.
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("sorted_priority_queue_top regression: pass");
    end else begin
      $display("sorted_priority_queue_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue_top.sv
hdl/spq_checker.sv
verif/sorted_priority_queue_top_tb.sv
